// ===== hw/rtl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// lms_pkg: shared types and constants for the LED matrix scan driver
// Grid geometry, item function codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int GRID_SIZE = 8;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int CODE_W    = 8;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CODE_W-1:0] EMPTY_RESET = 8'd4;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_WRITE = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CURSOR_ENABLE = 1'd0;
  localparam cfg_idx_t REG_EMPTY_CODE    = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MOD,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/lms_in_if.sv =====
// ----------------------------------------------------------------------------
// lms_in_if: input item channel
// Valid/ready channel carrying one tick, cell write or clear request.
// ----------------------------------------------------------------------------
interface lms_in_if;
  logic                                valid;
  logic                                ready;
  logic [lms_pkg::FUNC_W-1:0]          func;
  logic [lms_pkg::COORD_W-1:0]         cell_row;
  logic [lms_pkg::COORD_W-1:0]         cell_col;
  logic [lms_pkg::CODE_W-1:0]          cell_value;
  logic [lms_pkg::COORD_W-1:0]         cursor_x;
  logic [lms_pkg::COORD_W-1:0]         cursor_y;
  logic [lms_pkg::CODE_W-1:0]          cursor_value;

  modport source (
    output valid, func, cell_row, cell_col, cell_value, cursor_x, cursor_y, cursor_value,
    input  ready
  );
  modport sink (
    input  valid, func, cell_row, cell_col, cell_value, cursor_x, cursor_y, cursor_value,
    output ready
  );
endinterface

// ===== hw/rtl/lms_out_if.sv =====
// ----------------------------------------------------------------------------
// lms_out_if: result channel
// Valid/ready channel carrying the row select and column pattern of one tick.
// ----------------------------------------------------------------------------
interface lms_out_if;
  logic                                valid;
  logic                                ready;
  logic [lms_pkg::COORD_W-1:0]         row_index;
  logic [lms_pkg::GRID_SIZE-1:0]       row_drive_n;
  logic [lms_pkg::GRID_SIZE-1:0]       column_bits;

  modport source (
    output valid, row_index, row_drive_n, column_bits,
    input  ready
  );
  modport sink (
    input  valid, row_index, row_drive_n, column_bits,
    output ready
  );
endinterface

// ===== hw/rtl/led_matrix_scan_blink.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scan_blink: 8x8 multiplexed LED matrix driver with pixel blink
// Cell divisor store, row scan and per-column blink check on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. func selects scan tick, cell write or clear.
//   result : valid/ready output, one transfer per scan tick only.
//   cfg    : cfg_wen/cfg_index/cfg_data register write, taken in any cycle.
// Cell writes and clears are taken while idle and produce no result;
// ready stays high for them. A scan tick reads the eight cells of cell
// row 7 minus the driven row one after another from the cell RAM and
// checks each against the cycle counter in a shared shift-subtract
// remainder unit, one bit per cycle. Ready stays low until the finished
// result is loaded into the output register, so no item is taken mid-tick.
// The finished result sits in an output register; if it is still not
// taken when the next tick finishes, the block holds that tick until the
// register frees up.
// Reset clears the row and cycle counters and marks every cell empty by
// dropping per-cell valid bits, so no clearing pass is needed; a clear
// item marks every cell empty the same way, with the current empty code.
// ----------------------------------------------------------------------------
module led_matrix_scan_blink (
  input  logic                            clk,
  input  logic                            rst,
  lms_in_if.sink                          item,
  lms_out_if.source                       result,
  input  logic                            cfg_wen,
  input  logic [lms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lms_pkg::CODE_W-1:0]      cfg_data
);

  localparam int CW = lms_pkg::COORD_W;
  localparam int DW = lms_pkg::CODE_W;

  lms_pkg::state_t state, state_next;

  logic                       cursor_enable;
  logic [DW-1:0]              empty_code;
  logic [DW-1:0]              clear_value;
  logic [lms_pkg::CELLS-1:0]  cell_valid;
  logic [DW-1:0]              cycle_count;
  logic [CW-1:0]              scan_row;
  logic [CW-1:0]              col;
  logic [lms_pkg::GRID_SIZE-1:0] column_acc;
  logic [CW-1:0]              cur_x;
  logic [CW-1:0]              cur_y;
  logic [DW-1:0]              cur_v;

  logic                       accept;
  logic                       take_tick;
  logic                       take_write;
  logic                       take_clear;
  logic                       mod_start;
  logic                       mod_done;
  logic                       mod_multiple;
  logic                       load_out;
  logic                       last_col;
  logic [CW-1:0]              src_row;
  logic [lms_pkg::CELL_AW-1:0] rd_addr;
  logic [lms_pkg::CELL_AW-1:0] wr_addr;
  logic [DW-1:0]              rd_data;
  logic [DW-1:0]              cell_code;
  logic [DW-1:0]              divisor;
  logic [DW:0]                cc_inc;

  assign accept     = item.valid && item.ready;
  assign take_tick  = accept && (item.func == lms_pkg::FUNC_TICK);
  assign take_write = accept && (item.func == lms_pkg::FUNC_WRITE);
  assign take_clear = accept && (item.func == lms_pkg::FUNC_CLEAR);

  assign src_row  = CW'(lms_pkg::GRID_SIZE - 1) - scan_row;
  assign rd_addr  = {src_row, col};
  assign wr_addr  = {item.cell_row, item.cell_col};
  assign last_col = col == CW'(lms_pkg::GRID_SIZE - 1);
  assign cc_inc   = {1'b0, cycle_count} + 9'd1;

  assign cell_code = cell_valid[rd_addr] ? rd_data : clear_value;
  assign divisor   = (cursor_enable && src_row == cur_y && col == cur_x) ? cur_v : cell_code;

  lms_ram #(
    .WIDTH (DW),
    .DEPTH (lms_pkg::CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (take_write),
    .waddr (wr_addr),
    .wdata (item.cell_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lms_mod u_mod (
    .clk         (clk),
    .rst         (rst),
    .start       (mod_start),
    .dividend    (cycle_count),
    .divisor     (divisor),
    .done        (mod_done),
    .is_multiple (mod_multiple)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    mod_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      lms_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (take_tick) begin
          state_next = lms_pkg::S_READ;
        end
      end
      lms_pkg::S_READ: begin
        state_next = lms_pkg::S_LOAD;
      end
      lms_pkg::S_LOAD: begin
        mod_start  = 1'b1;
        state_next = lms_pkg::S_MOD;
      end
      lms_pkg::S_MOD: begin
        if (mod_done) begin
          state_next = last_col ? lms_pkg::S_EMIT : lms_pkg::S_READ;
        end
      end
      lms_pkg::S_EMIT: begin
        if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = lms_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lms_pkg::S_IDLE;
      end
    endcase
  end

  // configuration and store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_enable <= 1'b0;
      empty_code    <= lms_pkg::EMPTY_RESET;
      clear_value   <= lms_pkg::EMPTY_RESET;
      cell_valid    <= '0;
      cycle_count   <= '0;
      scan_row      <= '0;
    end else begin
      if (cfg_wen && cfg_index == lms_pkg::REG_CURSOR_ENABLE) begin
        cursor_enable <= cfg_data[0];
      end
      if (cfg_wen && cfg_index == lms_pkg::REG_EMPTY_CODE) begin
        empty_code <= cfg_data;
      end
      if (take_write) begin
        cell_valid[wr_addr] <= 1'b1;
      end
      if (take_clear) begin
        cell_valid  <= '0;
        clear_value <= empty_code;
      end
      if (take_tick) begin
        scan_row <= scan_row + 1'b1;
        // wrap back to one once the count reaches empty_code - 1
        if (cc_inc >= {1'b0, empty_code}) begin
          cycle_count <= 8'd1;
        end else begin
          cycle_count <= cc_inc[DW-1:0];
        end
      end
    end
  end

  // per-tick working registers
  always_ff @(posedge clk) begin
    if (take_tick) begin
      cur_x      <= item.cursor_x;
      cur_y      <= item.cursor_y;
      cur_v      <= item.cursor_value;
      col        <= '0;
      column_acc <= '0;
    end else if (state == lms_pkg::S_MOD && mod_done) begin
      column_acc[CW'(lms_pkg::GRID_SIZE - 1) - col] <= mod_multiple;
      if (!last_col) begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.row_index   <= scan_row;
      result.row_drive_n <= ~(lms_pkg::GRID_SIZE'(1) << scan_row);
      result.column_bits <= column_acc;
    end
  end

endmodule

// ===== hw/rtl/lms_ram.sv =====
// ----------------------------------------------------------------------------
// lms_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lms_mod.sv =====
// ----------------------------------------------------------------------------
// lms_mod: iterative remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle; reports
// whether the dividend is a nonzero-divisor multiple.
// ----------------------------------------------------------------------------
module lms_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lms_pkg::CODE_W-1:0]  dividend,
  input  logic [lms_pkg::CODE_W-1:0]  divisor,
  output logic                        done,
  output logic                        is_multiple
);

  localparam int CntW = $clog2(lms_pkg::CODE_W);

  logic                        run;
  logic [CntW-1:0]             cnt;
  logic [lms_pkg::CODE_W-1:0]  rem;
  logic [lms_pkg::CODE_W-1:0]  num;
  logic [lms_pkg::CODE_W-1:0]  div;
  logic [lms_pkg::CODE_W:0]    rem_sh;
  logic [lms_pkg::CODE_W:0]    rem_sub;
  logic                        fits;

  assign rem_sh  = {rem, num[lms_pkg::CODE_W-1]};
  assign fits    = rem_sh >= {1'b0, div};
  assign rem_sub = rem_sh - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(lms_pkg::CODE_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // for a nonzero divisor the remainder stays below it, so it fits the code width
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
      div <= divisor;
    end else if (run) begin
      rem <= fits ? rem_sub[lms_pkg::CODE_W-1:0] : rem_sh[lms_pkg::CODE_W-1:0];
      num <= {num[lms_pkg::CODE_W-2:0], 1'b0};
    end
  end

  assign is_multiple = (div != '0) && (rem == '0);

endmodule
